>>> design/round_robin_mutex_scheduler_assert.svh
// Assertion macros for the round-robin mutex scheduler.
`ifndef ROUND_ROBIN_MUTEX_SCHEDULER_ASSERT_SVH
`define ROUND_ROBIN_MUTEX_SCHEDULER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// The condition holds at every clock edge outside reset.
`define RRMS_ASSERT_ALWAYS(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("rrms: invariant violated");

// When the antecedent holds, the consequent holds in the same cycle.
`define RRMS_ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rrms: implication violated");

// When the antecedent holds, the consequent holds in the following cycle.
`define RRMS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rrms: sequence violated");

`else

`define RRMS_ASSERT_ALWAYS(label, cond)
`define RRMS_ASSERT_IMPLIES(label, ante, cons)
`define RRMS_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> design/rrms_pkg.sv
// Shared types and constants of the round-robin mutex scheduler.
`timescale 1ns / 1ps

package rrms_pkg;

   localparam int ID_W      = 2;
   localparam int CMD_W     = 3;
   localparam int RES_W     = 2;
   localparam int STATUS_W  = 2;
   localparam int COUNT_W   = 3;
   localparam int QUANTUM_W = 8;

   localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 8'd2;

   localparam int NUM_PROCS_DEFAULT = 4;
   localparam int NUM_LOCKS_DEFAULT = 3;

   typedef enum logic [CMD_W-1:0] {
      CMD_ARRIVE   = 3'd0,
      CMD_DISPATCH = 3'd1,
      CMD_WAIT     = 3'd2,
      CMD_SIGNAL   = 3'd3,
      CMD_STEP     = 3'd4,
      CMD_FINISH   = 3'd5
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_EMPTY     = 2'd2,
      STATUS_BAD_STATE = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_PUSH
   } state_type;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic [ID_W-1:0]  proc_id;
      logic [RES_W-1:0] resource;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                granted;
      logic                got_blocked;
      logic                woken_valid;
      logic [ID_W-1:0]     woken_id;
      logic                preempted;
      logic                running_valid;
      logic [ID_W-1:0]     running_id;
      logic [COUNT_W-1:0]  ready_count;
   } rsp_type;

endpackage

>>> design/round_robin_mutex_scheduler.sv
// A request beat is accepted only in the idle state, and no new event is taken before
// the last is committed; a signal that both wakes a waiter and preempts also passes
// through S_PUSH, since both go to the ready-slot memory through its single write port.
// The slot memories are read on acceptance and written back in the execute cycle.
// Reset is synchronous and active high; it clears the control state.
// The slot memories are not cleared: an entry is only used after it has been written.
`timescale 1ns / 1ps

module round_robin_mutex_scheduler
   import rrms_pkg::*;
#(
   parameter int NUM_PROCS = NUM_PROCS_DEFAULT,
   parameter int NUM_LOCKS = NUM_LOCKS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   // response channel
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   // quantum register write port
   input  logic                 csr_wr_en,
   input  logic [QUANTUM_W-1:0] csr_wr_data
);

`include "round_robin_mutex_scheduler_assert.svh"

   // Slot index, queue size, lock index and wait-memory address widths.
   localparam int PW     = $clog2(NUM_PROCS);
   localparam int CW     = $clog2(NUM_PROCS + 1);
   localparam int SW     = CW + 1;
   localparam int LW     = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;
   localparam int WDEPTH = NUM_LOCKS * NUM_PROCS;
   localparam int AW     = $clog2(WDEPTH);

   localparam logic [CW-1:0] FULL_SIZE = CW'(NUM_PROCS);

   // A head-plus-offset sum is always below twice the queue depth, so one
   // compare and subtract brings it back into range.
   function automatic logic [PW-1:0] wrap_slot(input logic [SW-1:0] sum);
      if (sum >= SW'(NUM_PROCS)) begin
         return PW'(sum - SW'(NUM_PROCS));
      end
      return PW'(sum);
   endfunction

   // Each lock owns a contiguous block of NUM_PROCS entries in the wait memory.
   function automatic logic [AW-1:0] slot_addr(input logic [LW-1:0] lock,
                                               input logic [PW-1:0] slot);
      return AW'(lock) * AW'(NUM_PROCS) + AW'(slot);
   endfunction

   // ------------------------------------------------------------------
   // State
   // ------------------------------------------------------------------
   state_type               state_ff, state_in;
   req_type                 req_ff;
   rsp_type                 rsp_data_ff, rsp_next;
   logic                    rsp_valid_ff;

   logic [QUANTUM_W-1:0]    quantum_ff;
   logic [PW-1:0]           ready_head_ff, ready_head_in;
   logic [CW-1:0]           ready_size_ff, ready_size_in;
   logic [PW-1:0]           wait_head_ff [NUM_LOCKS];
   logic [PW-1:0]           wait_head_in [NUM_LOCKS];
   logic [CW-1:0]           wait_size_ff [NUM_LOCKS];
   logic [CW-1:0]           wait_size_in [NUM_LOCKS];
   logic [NUM_LOCKS-1:0]    lock_held_ff, lock_held_in;
   logic                    run_valid_ff, run_valid_in;
   logic [ID_W-1:0]         run_id_ff, run_id_in;
   logic [QUANTUM_W-1:0]    slice_count_ff, slice_count_in;

   // The deferred second ready-slot write, performed in S_PUSH.
   logic [PW-1:0]           push_b_addr_ff;
   logic [ID_W-1:0]         push_b_data_ff;

   // ------------------------------------------------------------------
   // Handshake and control
   // ------------------------------------------------------------------
   logic accept;
   logic out_free;
   logic commit;
   logic push_phase;

   // The output register can take a new response when it is empty or its
   // current beat leaves at this edge.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // ------------------------------------------------------------------
   // Memory ports
   // ------------------------------------------------------------------
   logic            res_ok_now;
   logic [LW-1:0]   lock_now;
   logic [AW-1:0]   wait_rd_addr;
   logic [ID_W-1:0] ready_rd_data;
   logic [ID_W-1:0] wait_rd_data;

   logic            ready_wr_en;
   logic [PW-1:0]   ready_wr_addr;
   logic [ID_W-1:0] ready_wr_data;

   // Both memories are read on every accepted beat: the ready memory at the
   // queue head (for dispatch) and the wait memory at the head of the named
   // lock's queue (for signal). The execute cycle uses whichever it needs.
   assign res_ok_now   = int'(req_data.resource) < NUM_LOCKS;
   assign lock_now     = res_ok_now ? LW'(req_data.resource) : '0;
   assign wait_rd_addr = slot_addr(lock_now, wait_head_ff[lock_now]);

   // ------------------------------------------------------------------
   // Execute: decode the held request against the control state and the
   // registered read data, and work out every next value.
   // ------------------------------------------------------------------
   logic            res_ok;
   logic [LW-1:0]   lock_idx;
   logic [QUANTUM_W-1:0] slice_inc;
   logic            counts;
   status_type      status;
   logic            granted;
   logic            blocked;
   logic            woken_valid;
   logic [ID_W-1:0] woken_id;
   logic            preempted;
   logic            push_a_en;
   logic [PW-1:0]   push_a_addr;
   logic [ID_W-1:0] push_a_data;
   logic            push_b_en;
   logic [PW-1:0]   push_b_addr;
   logic [ID_W-1:0] push_b_data;
   logic            wait_we;
   logic [AW-1:0]   wait_wr_addr;

   assign res_ok   = int'(req_ff.resource) < NUM_LOCKS;
   assign lock_idx = res_ok ? LW'(req_ff.resource) : '0;

   // Instruction count saturates at its maximum.
   assign slice_inc = (slice_count_ff == '1) ? slice_count_ff : slice_count_ff + 1'b1;

   always_comb begin
      ready_head_in  = ready_head_ff;
      ready_size_in  = ready_size_ff;
      wait_head_in   = wait_head_ff;
      wait_size_in   = wait_size_ff;
      lock_held_in   = lock_held_ff;
      run_valid_in   = run_valid_ff;
      run_id_in      = run_id_ff;
      slice_count_in = slice_count_ff;

      status      = STATUS_OK;
      granted     = 1'b0;
      blocked     = 1'b0;
      woken_valid = 1'b0;
      woken_id    = '0;
      preempted   = 1'b0;
      counts      = 1'b0;

      push_a_en    = 1'b0;
      push_a_addr  = ready_head_ff;
      push_a_data  = '0;
      push_b_en    = 1'b0;
      push_b_addr  = ready_head_ff;
      push_b_data  = '0;
      wait_we      = 1'b0;
      wait_wr_addr = '0;

      unique case (req_ff.cmd) inside
         CMD_ARRIVE: begin
            // A newcomer goes in front of the head of the ready queue.
            if (ready_size_ff >= FULL_SIZE) begin
               status = STATUS_FULL;
            end else begin
               ready_head_in = (ready_head_ff == '0) ? PW'(NUM_PROCS - 1)
                                                     : ready_head_ff - 1'b1;
               push_a_en     = 1'b1;
               push_a_addr   = ready_head_in;
               push_a_data   = req_ff.proc_id;
               ready_size_in = ready_size_ff + 1'b1;
            end
         end
         CMD_DISPATCH: begin
            if (run_valid_ff) begin
               status = STATUS_BAD_STATE;
            end else if (ready_size_ff == '0) begin
               status = STATUS_EMPTY;
            end else begin
               run_id_in      = ready_rd_data;
               ready_head_in  = wrap_slot(SW'(ready_head_ff) + SW'(1));
               ready_size_in  = ready_size_ff - 1'b1;
               run_valid_in   = 1'b1;
               slice_count_in = '0;
            end
         end
         CMD_WAIT, CMD_SIGNAL, CMD_STEP, CMD_FINISH: begin
            if (!run_valid_ff) begin
               status = STATUS_BAD_STATE;
            end else if (req_ff.cmd == CMD_FINISH) begin
               run_valid_in   = 1'b0;
               slice_count_in = '0;
            end else if (req_ff.cmd == CMD_WAIT && res_ok) begin
               if (lock_held_ff[lock_idx]) begin
                  // Held lock: park the running process at the tail of the
                  // lock's wait queue, unless that queue is already full.
                  if (wait_size_ff[lock_idx] >= FULL_SIZE) begin
                     status = STATUS_FULL;
                  end else begin
                     wait_we      = 1'b1;
                     wait_wr_addr = slot_addr(lock_idx,
                        wrap_slot(SW'(wait_head_ff[lock_idx]) + SW'(wait_size_ff[lock_idx])));
                     wait_size_in[lock_idx] = wait_size_ff[lock_idx] + 1'b1;
                     run_valid_in   = 1'b0;
                     slice_count_in = '0;
                     blocked        = 1'b1;
                  end
               end else begin
                  lock_held_in[lock_idx] = 1'b1;
                  granted = 1'b1;
                  counts  = 1'b1;
               end
            end else if (req_ff.cmd == CMD_SIGNAL && res_ok) begin
               if (wait_size_ff[lock_idx] != '0) begin
                  // Hand the lock to the oldest waiter; it stays held.
                  if (ready_size_ff >= FULL_SIZE) begin
                     status = STATUS_FULL;
                  end else begin
                     woken_id = wait_rd_data;
                     wait_head_in[lock_idx] =
                        wrap_slot(SW'(wait_head_ff[lock_idx]) + SW'(1));
                     wait_size_in[lock_idx] = wait_size_ff[lock_idx] - 1'b1;
                     push_a_en     = 1'b1;
                     push_a_addr   = wrap_slot(SW'(ready_head_ff) + SW'(ready_size_ff));
                     push_a_data   = wait_rd_data;
                     ready_size_in = ready_size_ff + 1'b1;
                     woken_valid   = 1'b1;
                     counts        = 1'b1;
                  end
               end else begin
                  lock_held_in[lock_idx] = 1'b0;
                  counts = 1'b1;
               end
            end else begin
               // Step, or a wait or signal naming a lock that does not exist.
               counts = 1'b1;
            end
         end
         default: begin
         end
      endcase

      // Quantum accounting for instructions that took effect.
      if (counts) begin
         slice_count_in = slice_inc;
         if (slice_inc >= quantum_ff) begin
            if (ready_size_in >= FULL_SIZE) begin
               // No room to requeue: keep running and try after the next one.
               status = STATUS_FULL;
            end else begin
               if (push_a_en) begin
                  push_b_en   = 1'b1;
                  push_b_addr = wrap_slot(SW'(ready_head_in) + SW'(ready_size_in));
                  push_b_data = run_id_ff;
               end else begin
                  push_a_en   = 1'b1;
                  push_a_addr = wrap_slot(SW'(ready_head_in) + SW'(ready_size_in));
                  push_a_data = run_id_ff;
               end
               ready_size_in  = ready_size_in + 1'b1;
               run_valid_in   = 1'b0;
               slice_count_in = '0;
               preempted      = 1'b1;
            end
         end
      end
   end

   always_comb begin
      rsp_next.status        = status;
      rsp_next.granted       = granted;
      rsp_next.got_blocked   = blocked;
      rsp_next.woken_valid   = woken_valid;
      rsp_next.woken_id      = woken_id;
      rsp_next.preempted     = preempted;
      rsp_next.running_valid = run_valid_in;
      rsp_next.running_id    = run_valid_in ? run_id_in : '0;
      rsp_next.ready_count   = COUNT_W'(ready_size_in);
   end

   // ------------------------------------------------------------------
   // Sequencer: idle, execute, and an optional second ready-slot write.
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (out_free) begin
               state_in = push_b_en ? S_PUSH : S_IDLE;
            end
         end
         S_PUSH: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall  = 1'b1;
      accept     = 1'b0;
      commit     = 1'b0;
      push_phase = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            accept    = req_valid;
         end
         S_EXEC: begin
            commit = out_free;
         end
         S_PUSH: begin
            push_phase = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      if (commit) begin
         rsp_data_ff <= rsp_next;
      end
      if (commit && push_b_en) begin
         push_b_addr_ff <= push_b_addr;
         push_b_data_ff <= push_b_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quantum_ff     <= QUANTUM_RESET;
         ready_head_ff  <= '0;
         ready_size_ff  <= '0;
         lock_held_ff   <= '0;
         run_valid_ff   <= 1'b0;
         run_id_ff      <= '0;
         slice_count_ff <= '0;
         for (int i = 0; i < NUM_LOCKS; i++) begin
            wait_head_ff[i] <= '0;
            wait_size_ff[i] <= '0;
         end
      end else begin
         if (csr_wr_en) begin
            quantum_ff <= csr_wr_data;
         end
         if (commit) begin
            ready_head_ff  <= ready_head_in;
            ready_size_ff  <= ready_size_in;
            wait_head_ff   <= wait_head_in;
            wait_size_ff   <= wait_size_in;
            lock_held_ff   <= lock_held_in;
            run_valid_ff   <= run_valid_in;
            run_id_ff      <= run_id_in;
            slice_count_ff <= slice_count_in;
         end
      end
   end

   // ------------------------------------------------------------------
   // Slot memories
   // ------------------------------------------------------------------
   assign ready_wr_en   = (commit && push_a_en) || push_phase;
   assign ready_wr_addr = push_phase ? push_b_addr_ff : push_a_addr;
   assign ready_wr_data = push_phase ? push_b_data_ff : push_a_data;

   rrms_slot_ram #(
      .DEPTH  (NUM_PROCS),
      .DATA_W (ID_W)
   ) u_ready_ram (
      .clock   (clock),
      .wr_en   (ready_wr_en),
      .wr_addr (ready_wr_addr),
      .wr_data (ready_wr_data),
      .rd_en   (accept),
      .rd_addr (ready_head_ff),
      .rd_data (ready_rd_data)
   );

   rrms_slot_ram #(
      .DEPTH  (WDEPTH),
      .DATA_W (ID_W)
   ) u_wait_ram (
      .clock   (clock),
      .wr_en   (commit && wait_we),
      .wr_addr (wait_wr_addr),
      .wr_data (run_id_ff),
      .rd_en   (accept),
      .rd_addr (wait_rd_addr),
      .rd_data (wait_rd_data)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   // The ready queue never holds more entries than there are slots.
   `RRMS_ASSERT_ALWAYS(a_ready_size_bound, ready_size_ff <= FULL_SIZE)
   // With nothing on the processor the instruction count is always cleared.
   `RRMS_ASSERT_IMPLIES(a_idle_slice_clear, !run_valid_ff, slice_count_ff == '0)
   // A response beat only appears out of the execute cycle.
   `RRMS_ASSERT_NEXT(a_rsp_from_exec, !rsp_valid_ff && state_ff != S_EXEC, !rsp_valid_ff)

endmodule

>>> design/rrms_slot_ram.sv
// Single-port-write, registered-read slot memory for process identifiers.
`timescale 1ns / 1ps

module rrms_slot_ram
   import rrms_pkg::*;
#(
   parameter int DEPTH  = NUM_PROCS_DEFAULT,
   parameter int DATA_W = ID_W,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> test/tb_top.sv
// Self-checking testbench for the round-robin mutex scheduler.
`timescale 1ns / 1ps

module tb_top;
   import rrms_pkg::*;

   localparam int NP = NUM_PROCS_DEFAULT;
   localparam int NL = NUM_LOCKS_DEFAULT;

   // Command codes beyond the defined set; the block must ignore them.
   localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

   // Lock numbers. The last code names no lock and behaves like a step.
   localparam logic [RES_W-1:0] RES_INPUT  = 2'd0;
   localparam logic [RES_W-1:0] RES_FILE   = 2'd1;
   localparam logic [RES_W-1:0] RES_OUTPUT = 2'd2;
   localparam logic [RES_W-1:0] RES_NONE   = 2'd3;

   localparam logic [QUANTUM_W-1:0] SLICE_MAX = '1;

   // Quiet cycles left after the last response is in, before touching the quantum register.
   localparam int SETTLE_CYCLES = 4;
   // Enough steps to push the slice counter into saturation.
   localparam int SATURATION_STEPS = 260;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_type              req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_wr_en = 1'b0;
   logic [QUANTUM_W-1:0] csr_wr_data = '0;

   round_robin_mutex_scheduler #(
      .NUM_PROCS(NP),
      .NUM_LOCKS(NL)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Shadow copy of the scheduler: ready ring, per-lock wait rings, lock
   // flags, the processor slot and the slice counter.
   logic [ID_W-1:0]      rdy_slot [NP];
   logic [ID_W-1:0]      rdy_head = '0;
   logic [COUNT_W-1:0]   rdy_size = '0;
   logic [ID_W-1:0]      lk_wait [NL][NP];
   logic [ID_W-1:0]      lk_head [NL] = '{default: '0};
   logic [COUNT_W-1:0]   lk_size [NL] = '{default: '0};
   logic                 lk_held [NL] = '{default: 1'b0};
   logic                 cpu_busy = 1'b0;
   logic [ID_W-1:0]      cpu_id = '0;
   logic [QUANTUM_W-1:0] slice = '0;
   logic [QUANTUM_W-1:0] quantum_reg = QUANTUM_RESET;

   // Outcomes predicted for accepted request beats, oldest first.
   rsp_type     due_outcomes [$];
   int unsigned failures = 0;

   // When cleared, neither side inserts gaps or stalls of its own accord.
   bit          idle_on = 1'b1;
   // Set by a test to make the receiver refuse responses for that many cycles.
   int unsigned hold_cycles = 0;

   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(99, 0);
      if (!idle_on || roll < 55)
         return 0;
      if (roll < 92)
         return $urandom_range(3, 1);
      return $urandom_range(20, 6);
   endfunction

   function automatic void push_ready_tail(input logic [ID_W-1:0] id);
      rdy_slot[rdy_head + rdy_size[ID_W-1:0]] = id;
      rdy_size = rdy_size + 1'b1;
   endfunction

   // Applies one event to the shadow state and returns the response that the
   // block should produce for it.
   function automatic rsp_type schedule_outcome(input req_type ev);
      rsp_type          out;
      logic             counts;
      logic [RES_W-1:0] r;
      logic [ID_W-1:0]  pos;
      logic [ID_W-1:0]  wid;
      out = '0;
      counts = 1'b0;
      r = ev.resource;
      case (ev.cmd)
         CMD_ARRIVE: begin
            // Arrivals jump the queue.
            if (rdy_size >= NP) begin
               out.status = STATUS_FULL;
            end else begin
               rdy_head = rdy_head - 1'b1;
               rdy_slot[rdy_head] = ev.proc_id;
               rdy_size = rdy_size + 1'b1;
            end
         end
         CMD_DISPATCH: begin
            if (cpu_busy) begin
               out.status = STATUS_BAD_STATE;
            end else if (rdy_size == 0) begin
               out.status = STATUS_EMPTY;
            end else begin
               cpu_id = rdy_slot[rdy_head];
               rdy_head = rdy_head + 1'b1;
               rdy_size = rdy_size - 1'b1;
               cpu_busy = 1'b1;
               slice = '0;
            end
         end
         CMD_WAIT, CMD_SIGNAL, CMD_STEP, CMD_FINISH: begin
            if (!cpu_busy) begin
               out.status = STATUS_BAD_STATE;
            end else if (ev.cmd == CMD_FINISH) begin
               cpu_busy = 1'b0;
               slice = '0;
            end else if (ev.cmd == CMD_WAIT && r < NL) begin
               if (lk_held[r]) begin
                  if (lk_size[r] >= NP) begin
                     out.status = STATUS_FULL;
                  end else begin
                     pos = lk_head[r] + lk_size[r][ID_W-1:0];
                     lk_wait[r][pos] = cpu_id;
                     lk_size[r] = lk_size[r] + 1'b1;
                     cpu_busy = 1'b0;
                     slice = '0;
                     out.got_blocked = 1'b1;
                  end
               end else begin
                  lk_held[r] = 1'b1;
                  out.granted = 1'b1;
                  counts = 1'b1;
               end
            end else if (ev.cmd == CMD_SIGNAL && r < NL) begin
               if (lk_size[r] != 0) begin
                  // The lock passes straight to the oldest waiter.
                  if (rdy_size >= NP) begin
                     out.status = STATUS_FULL;
                  end else begin
                     wid = lk_wait[r][lk_head[r]];
                     lk_head[r] = lk_head[r] + 1'b1;
                     lk_size[r] = lk_size[r] - 1'b1;
                     push_ready_tail(wid);
                     out.woken_valid = 1'b1;
                     out.woken_id = wid;
                     counts = 1'b1;
                  end
               end else begin
                  lk_held[r] = 1'b0;
                  counts = 1'b1;
               end
            end else begin
               counts = 1'b1;
            end
         end
         default: ;
      endcase
      if (counts) begin
         if (slice != SLICE_MAX)
            slice = slice + 1'b1;
         // A full ready queue keeps the process on the processor; it is
         // tried again after its next counted instruction.
         if (slice >= quantum_reg) begin
            if (rdy_size >= NP) begin
               out.status = STATUS_FULL;
            end else begin
               push_ready_tail(cpu_id);
               cpu_busy = 1'b0;
               slice = '0;
               out.preempted = 1'b1;
            end
         end
      end
      out.running_valid = cpu_busy;
      out.running_id = cpu_busy ? cpu_id : '0;
      out.ready_count = rdy_size;
      return out;
   endfunction

   // Offers one request beat, holds it until accepted, predicts its outcome
   // at the accepting edge and then leaves a random gap.
   task automatic send_event(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] pid,
                             input logic [RES_W-1:0] res);
      req_type     ev;
      int unsigned gap;
      ev.cmd = cmd;
      ev.proc_id = pid;
      ev.resource = res;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= ev;
      do @(posedge clock); while (req_stall !== 1'b0);
      due_outcomes.push_back(schedule_outcome(ev));
      gap = pick_gap();
      if (gap != 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // Stops offering beats and waits until every predicted response is in.
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (due_outcomes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_quantum(input logic [QUANTUM_W-1:0] value);
      drain();
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      quantum_reg = value;
   endtask

   // Mostly events that make sense in the present state, with some noise.
   function automatic req_type pick_event();
      req_type     ev;
      int unsigned roll;
      ev.proc_id = ID_W'($urandom_range(3, 0));
      ev.resource = ($urandom_range(19, 0) == 0) ? RES_NONE
                                                 : RES_W'($urandom_range(2, 0));
      roll = $urandom_range(99, 0);
      if (roll < 12) begin
         ev.cmd = CMD_W'($urandom_range(7, 0));
         ev.resource = RES_W'($urandom_range(3, 0));
      end else if (!cpu_busy) begin
         ev.cmd = (rdy_size == 0 || (rdy_size < NP && roll < 40)) ? CMD_ARRIVE : CMD_DISPATCH;
      end else if (roll < 42) begin
         ev.cmd = CMD_WAIT;
      end else if (roll < 70) begin
         ev.cmd = CMD_SIGNAL;
      end else if (roll < 85) begin
         ev.cmd = CMD_STEP;
      end else if (roll < 95) begin
         ev.cmd = CMD_FINISH;
      end else begin
         ev.cmd = CMD_ARRIVE;
      end
      return ev;
   endfunction

   // Ignored codes do not count toward the number of events asked for.
   task automatic random_events(input int unsigned count);
      req_type     ev;
      int unsigned done;
      done = 0;
      while (done < count) begin
         ev = pick_event();
         send_event(ev.cmd, ev.proc_id, ev.resource);
         if (ev.cmd <= CMD_FINISH)
            done++;
      end
   endtask

   // Instructions with nothing on the processor, an empty dispatch and the
   // spare command codes, all under the reset quantum.
   task automatic test_idle_errors();
      send_event(CMD_DISPATCH, 2'd0, RES_INPUT);
      send_event(CMD_STEP, 2'd0, RES_INPUT);
      send_event(CMD_SIGNAL, 2'd3, RES_OUTPUT);
      send_event(CMD_SPARE_LO, 2'd1, RES_FILE);
      send_event(CMD_SPARE_HI, 2'd3, RES_NONE);
   endtask

   // Fills the ready queue and the wait queue of one lock, then wakes
   // waiters, including into a full ready queue. The quantum is at its top
   // so that no preemption gets in the way.
   task automatic test_lock_queues();
      set_quantum(SLICE_MAX);
      send_event(CMD_ARRIVE, 2'd3, RES_INPUT);
      send_event(CMD_ARRIVE, 2'd2, RES_INPUT);
      send_event(CMD_ARRIVE, 2'd1, RES_INPUT);
      send_event(CMD_ARRIVE, 2'd0, RES_INPUT);
      send_event(CMD_ARRIVE, 2'd3, RES_INPUT);
      send_event(CMD_DISPATCH, 2'd0, RES_INPUT);
      send_event(CMD_DISPATCH, 2'd0, RES_INPUT);
      send_event(CMD_WAIT, 2'd0, RES_INPUT);
      send_event(CMD_WAIT, 2'd0, RES_NONE);
      send_event(CMD_SIGNAL, 2'd0, RES_NONE);
      // Four processes pile up on the input lock.
      repeat (4) begin
         send_event(CMD_WAIT, 2'd0, RES_INPUT);
         send_event(CMD_DISPATCH, 2'd0, RES_INPUT);
      end
      send_event(CMD_ARRIVE, 2'd1, RES_INPUT);
      send_event(CMD_DISPATCH, 2'd0, RES_INPUT);
      send_event(CMD_WAIT, 2'd0, RES_INPUT);
      send_event(CMD_SIGNAL, 2'd0, RES_INPUT);
      send_event(CMD_ARRIVE, 2'd2, RES_INPUT);
      send_event(CMD_ARRIVE, 2'd3, RES_INPUT);
      send_event(CMD_ARRIVE, 2'd0, RES_INPUT);
      send_event(CMD_SIGNAL, 2'd0, RES_INPUT);
      send_event(CMD_WAIT, 2'd0, RES_FILE);
      send_event(CMD_SIGNAL, 2'd0, RES_OUTPUT);
   endtask

   // With a quantum of one every counted instruction tries to preempt. While the ready
   // queue is full the process stays on, also after a wake; the last step finds room.
   task automatic test_preempt_full();
      set_quantum(8'd1);
      send_event(CMD_STEP, 2'd0, RES_INPUT);
      send_event(CMD_FINISH, 2'd0, RES_INPUT);
      send_event(CMD_DISPATCH, 2'd0, RES_INPUT);
      send_event(CMD_SIGNAL, 2'd0, RES_INPUT);
      send_event(CMD_STEP, 2'd0, RES_INPUT);
      send_event(CMD_FINISH, 2'd0, RES_INPUT);
      send_event(CMD_DISPATCH, 2'd0, RES_INPUT);
      send_event(CMD_STEP, 2'd0, RES_INPUT);
   endtask

   task automatic test_random_traffic(input logic [QUANTUM_W-1:0] quantum,
                                      input int unsigned count, input bit gaps);
      set_quantum(quantum);
      idle_on = gaps;
      random_events(count);
      idle_on = 1'b1;
   endtask

   // The receiver refuses responses for a long stretch while beats keep
   // coming without gaps, so the block backs up into its request channel.
   task automatic test_backpressure();
      set_quantum(QUANTUM_RESET);
      idle_on = 1'b0;
      hold_cycles = 40;
      random_events(16);
      idle_on = 1'b1;
   endtask

   // Runs one process far past the top quantum with the ready queue full, so
   // the slice counter reaches and sticks at its maximum, after which every step reports full.
   task automatic test_slice_saturation();
      set_quantum(SLICE_MAX);
      while (!(cpu_busy && rdy_size == NP)) begin
         if (!cpu_busy && rdy_size != 0)
            send_event(CMD_DISPATCH, 2'd0, RES_INPUT);
         else
            send_event(CMD_ARRIVE, ID_W'($urandom_range(3, 0)), RES_INPUT);
      end
      repeat (SATURATION_STEPS) send_event(CMD_STEP, ID_W'($urandom_range(3, 0)), RES_FILE);
      send_event(CMD_FINISH, 2'd0, RES_INPUT);
   endtask

   initial begin : stimulus
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      test_idle_errors();
      test_lock_queues();
      test_preempt_full();
      test_random_traffic(SLICE_MAX, 20, 1'b1);
      test_random_traffic(8'd1, 15, 1'b1);
      test_random_traffic(8'd3, 15, 1'b0);
      test_random_traffic(8'd0, 15, 1'b1);
      test_backpressure();
      test_random_traffic(QUANTUM_W'($urandom_range(254, 4)), 15, 1'b1);
      test_random_traffic(QUANTUM_RESET, 12, 1'b1);
      test_slice_saturation();
      drain();
      if (due_outcomes.size() != 0) begin
         $error("%0d predicted responses never arrived", due_outcomes.size());
         failures++;
      end
      if (failures == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   // Receiver: random stall stretches, or a long hold when a test asks.
   initial begin : rsp_stall_gen
      int unsigned span;
      span = 0;
      forever begin
         @(negedge clock);
         if (hold_cycles != 0) begin
            rsp_stall <= 1'b1;
            hold_cycles--;
         end else if (span != 0) begin
            span--;
         end else begin
            span = pick_gap();
            rsp_stall <= (span != 0);
         end
      end
   end

   task automatic check_field(input string field, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, actual %0d", field, want, got);
         failures++;
      end
   endtask

   // Every response beat is matched against the oldest prediction.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (due_outcomes.size() == 0) begin
            $error("response beat with no request outstanding");
            failures++;
         end else begin
            want = due_outcomes.pop_front();
            check_field("status", 8'(want.status), 8'(rsp_data.status));
            check_field("granted", 8'(want.granted), 8'(rsp_data.granted));
            check_field("got_blocked", 8'(want.got_blocked), 8'(rsp_data.got_blocked));
            check_field("woken_valid", 8'(want.woken_valid), 8'(rsp_data.woken_valid));
            check_field("woken_id", 8'(want.woken_id), 8'(rsp_data.woken_id));
            check_field("preempted", 8'(want.preempted), 8'(rsp_data.preempted));
            check_field("running_valid", 8'(want.running_valid),
                        8'(rsp_data.running_valid));
            check_field("running_id", 8'(want.running_id), 8'(rsp_data.running_id));
            check_field("ready_count", 8'(want.ready_count), 8'(rsp_data.ready_count));
         end
      end
   end

   // Watchdog, far beyond the slowest legal run.
   initial begin : watchdog
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
